/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hw/rtl/bsp_pkg.sv */
// Types and constants of the bencode stream parser.
`timescale 1ns / 1ps

package bsp_pkg;

   localparam int MAX_DEPTH = 64;
   localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
   localparam int IDX_W     = $clog2(MAX_DEPTH);
   localparam int NEST_W    = 7;

   localparam logic [62:0] INT_MAX_MAG = 63'h7FFF_FFFF_FFFF_FFFF;

   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_I     = 8'h69;
   localparam logic [7:0] CH_L     = 8'h6C;

   typedef enum logic [3:0] {
      EV_LIST_START = 4'd0,
      EV_LIST_END   = 4'd1,
      EV_DICT_START = 4'd2,
      EV_DICT_END   = 4'd3,
      EV_INT        = 4'd4,
      EV_STR_START  = 4'd5,
      EV_STR_BYTE   = 4'd6,
      EV_DONE       = 4'd7,
      EV_ERROR      = 4'd8
   } event_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_MALFORMED = 2'd1,
      ERR_RANGE     = 2'd2,
      ERR_PREMATURE = 2'd3
   } error_type;

   typedef enum logic [4:0] {
      MODE_IDLE    = 5'b00001,
      MODE_INT     = 5'b00010,
      MODE_LEN     = 5'b00100,
      MODE_PAYLOAD = 5'b01000,
      MODE_DONE    = 5'b10000
   } mode_type;

   typedef struct packed {
      logic [NEST_W-1:0] nesting_level;
      error_type         error_code;
      logic              last_payload;
      logic [7:0]        payload_byte;
      logic [31:0]       string_length;
      logic [63:0]       int_value;
      event_type         event_kind;
   } rsp_type;

endpackage

/* hw/rtl/bencode_stream_parser.sv */
// Top level of the bencode stream parser.
`timescale 1ns / 1ps

// Streaming bencode parser. Each req item is one stream byte (req_tdata) or,
// with req_tuser set, the end-of-stream mark. Every accepted item yields at
// most one rsp item: container start/end, a signed 64-bit integer, a string
// start with its length, one item per payload byte (tlast on the final one),
// done, or an error. After an error or done the block is silent until reset.
// Throughput is one item per clock while rsp_tready is high. An accepted item
// passes the input register, then parse logic into the result register. While
// a result waits with rsp_tready low, the input stage holds and req_tready
// drops once it is full. The container-kind stack is a 64 x 1 memory; the
// top entry lives in a flop and the one below it is prefetched every cycle,
// so pops never wait on the memory read. No clearing pass is needed after
// reset. csr_data sets the largest accepted string length (reset value all
// ones) and is always ready; write it only while idle.
module bencode_stream_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tuser,   // [0] end_of_input
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,   // [63:0] int_value, [95:64] string_length,
                                     // [103:96] payload_byte, [105:104] error_code,
                                     // [112:106] nesting_level, rest zero
   output logic [3:0]   rsp_tuser,   // [3:0] event_kind
   output logic         rsp_tlast,   // last_payload
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data     // max_string_length
);
   import bsp_pkg::*;

   // config
   logic [31:0] max_len_ff;

   // input stage
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eoi_ff;
   logic       adv;

   // parse state
   mode_type     mode_ff, mode_in;
   logic         err_ff, err_in;
   logic [62:0]  acc_ff, acc_in;
   logic         minus_ff, minus_in;
   logic         digit_ff, digit_in;
   logic [31:0]  len_ff, len_in;
   logic [31:0]  rem_ff, rem_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;

   // stack: top in a flop, rest in memory, next-below prefetched
   logic               top_ff, top_in;
   logic               below_ff;
   logic               push;
   logic               stack_mem [MAX_DEPTH];
   logic [IDX_W-1:0]   wr_addr;
   logic [IDX_W-1:0]   rd_addr;

   // result stage
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // datapath helpers
   logic        is_digit;
   logic [3:0]  dval;
   logic [66:0] int_next;
   logic [35:0] len_next;
   logic        emit;

   assign csr_ready  = 1'b1;
   assign adv        = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || adv;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.event_kind;
   assign rsp_tlast  = rsp_ff.last_payload;
   assign rsp_tdata  = {7'd0, rsp_ff.nesting_level, rsp_ff.error_code,
                        rsp_ff.payload_byte, rsp_ff.string_length, rsp_ff.int_value};

   assign is_digit = in_byte_ff inside {[CH_0:CH_9]};
   assign dval     = 4'(in_byte_ff - CH_0);
   // acc*10 + d, wide enough that any overflow shows in the compare
   assign int_next = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {63'd0, dval};
   assign len_next = {1'b0, len_ff, 3'b000} + {3'b000, len_ff, 1'b0} + {32'd0, dval};

   always_comb begin
      mode_in   = mode_ff;
      err_in    = err_ff;
      acc_in    = acc_ff;
      minus_in  = minus_ff;
      digit_in  = digit_ff;
      len_in    = len_ff;
      rem_in    = rem_ff;
      depth_in  = depth_ff;
      top_in    = top_ff;
      push      = 1'b0;
      emit      = 1'b0;
      rsp_in    = '0;

      if (adv && !err_ff && mode_ff != MODE_DONE) begin
         if (in_eoi_ff) begin
            emit = 1'b1;
            if (mode_ff == MODE_IDLE && depth_ff == '0) begin
               mode_in = MODE_DONE;
               rsp_in.event_kind = EV_DONE;
            end else begin
               err_in = 1'b1;
               rsp_in.event_kind = EV_ERROR;
               rsp_in.error_code = ERR_PREMATURE;
            end
         end else begin
            case (mode_ff)
               MODE_IDLE: begin
                  if (in_byte_ff inside {CH_D, CH_L}) begin
                     emit = 1'b1;
                     if (depth_ff >= DEPTH_W'(MAX_DEPTH)) begin
                        err_in = 1'b1;
                        rsp_in.event_kind = EV_ERROR;
                        rsp_in.error_code = ERR_RANGE;
                     end else begin
                        push     = (depth_ff != '0);
                        top_in   = (in_byte_ff == CH_D);
                        depth_in = depth_ff + 1'b1;
                        rsp_in.event_kind = (in_byte_ff == CH_D) ? EV_DICT_START
                                                                 : EV_LIST_START;
                     end
                  end else if (in_byte_ff == CH_E) begin
                     emit = 1'b1;
                     if (depth_ff == '0) begin
                        err_in = 1'b1;
                        rsp_in.event_kind = EV_ERROR;
                        rsp_in.error_code = ERR_MALFORMED;
                     end else begin
                        depth_in = depth_ff - 1'b1;
                        top_in   = below_ff;
                        rsp_in.event_kind = top_ff ? EV_DICT_END : EV_LIST_END;
                     end
                  end else if (in_byte_ff == CH_I) begin
                     mode_in  = MODE_INT;
                     acc_in   = '0;
                     minus_in = 1'b0;
                     digit_in = 1'b0;
                  end else if (is_digit) begin
                     if ({28'd0, dval} > max_len_ff) begin
                        emit   = 1'b1;
                        err_in = 1'b1;
                        rsp_in.event_kind = EV_ERROR;
                        rsp_in.error_code = ERR_RANGE;
                     end else begin
                        len_in  = {28'd0, dval};
                        mode_in = MODE_LEN;
                     end
                  end else begin
                     emit   = 1'b1;
                     err_in = 1'b1;
                     rsp_in.event_kind = EV_ERROR;
                     rsp_in.error_code = ERR_MALFORMED;
                  end
               end
               MODE_INT: begin
                  if (is_digit) begin
                     if (acc_ff == '0 && digit_ff) begin
                        emit   = 1'b1;
                        err_in = 1'b1;
                        rsp_in.event_kind = EV_ERROR;
                        rsp_in.error_code = ERR_MALFORMED;
                     end else if (int_next > {4'd0, INT_MAX_MAG}) begin
                        emit   = 1'b1;
                        err_in = 1'b1;
                        rsp_in.event_kind = EV_ERROR;
                        rsp_in.error_code = ERR_RANGE;
                     end else begin
                        acc_in   = int_next[62:0];
                        digit_in = 1'b1;
                     end
                  end else if (in_byte_ff == CH_E) begin
                     emit = 1'b1;
                     if (minus_ff && acc_ff == '0) begin
                        err_in = 1'b1;
                        rsp_in.event_kind = EV_ERROR;
                        rsp_in.error_code = ERR_MALFORMED;
                     end else begin
                        mode_in = MODE_IDLE;
                        rsp_in.event_kind = EV_INT;
                        rsp_in.int_value  = minus_ff ? (64'd0 - {1'b0, acc_ff})
                                                     : {1'b0, acc_ff};
                     end
                  end else if (in_byte_ff == CH_MINUS && !minus_ff && !digit_ff) begin
                     minus_in = 1'b1;
                  end else begin
                     emit   = 1'b1;
                     err_in = 1'b1;
                     rsp_in.event_kind = EV_ERROR;
                     rsp_in.error_code = ERR_MALFORMED;
                  end
               end
               MODE_LEN: begin
                  if (is_digit) begin
                     if (len_ff == '0) begin
                        emit   = 1'b1;
                        err_in = 1'b1;
                        rsp_in.event_kind = EV_ERROR;
                        rsp_in.error_code = ERR_MALFORMED;
                     end else if (len_next > {4'd0, max_len_ff}) begin
                        emit   = 1'b1;
                        err_in = 1'b1;
                        rsp_in.event_kind = EV_ERROR;
                        rsp_in.error_code = ERR_RANGE;
                     end else begin
                        len_in = len_next[31:0];
                     end
                  end else if (in_byte_ff == CH_COLON) begin
                     emit    = 1'b1;
                     rem_in  = len_ff;
                     mode_in = (len_ff == '0) ? MODE_IDLE : MODE_PAYLOAD;
                     rsp_in.event_kind    = EV_STR_START;
                     rsp_in.string_length = len_ff;
                  end else begin
                     emit   = 1'b1;
                     err_in = 1'b1;
                     rsp_in.event_kind = EV_ERROR;
                     rsp_in.error_code = ERR_MALFORMED;
                  end
               end
               MODE_PAYLOAD: begin
                  emit   = 1'b1;
                  rem_in = (rem_ff != '0) ? rem_ff - 1'b1 : rem_ff;
                  if (rem_in == '0) begin
                     mode_in = MODE_IDLE;
                  end
                  rsp_in.event_kind   = EV_STR_BYTE;
                  rsp_in.payload_byte = in_byte_ff;
                  rsp_in.last_payload = (rem_in == '0);
               end
               default: begin
                  mode_in = mode_ff;
               end
            endcase
         end
      end

      // depth after the event; on error the depth is unchanged
      rsp_in.nesting_level = NEST_W'(depth_in);

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // entry below the new top, after this cycle's push
   assign wr_addr = IDX_W'(depth_ff - 1'b1);
   assign rd_addr = IDX_W'(depth_in - 2'd2);

   always_ff @(posedge clock) begin
      if (push) begin
         stack_mem[wr_addr] <= top_ff;
      end
      below_ff <= push ? top_ff : stack_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= '1;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_IDLE;
         err_ff       <= 1'b0;
         acc_ff       <= '0;
         minus_ff     <= 1'b0;
         digit_ff     <= 1'b0;
         len_ff       <= '0;
         rem_ff       <= '0;
         depth_ff     <= '0;
      end else begin
         if (csr_valid) begin
            max_len_ff <= csr_data;
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         err_ff       <= err_in;
         acc_ff       <= acc_in;
         minus_ff     <= minus_in;
         digit_ff     <= digit_in;
         len_ff       <= len_in;
         rem_ff       <= rem_in;
         depth_ff     <= depth_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_eoi_ff  <= req_tuser;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

/* hw/rtl/bsp_checker.sv */
// Port-level checker for the bencode stream parser, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsp_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [119:0] rsp_tdata,
   input logic [3:0]   rsp_tuser,
   input logic         rsp_tlast
);
   import bsp_pkg::*;

   logic rsp_take;
   logic final_take;

   assign rsp_take   = rsp_tvalid && rsp_tready;
   assign final_take = rsp_take && (rsp_tuser == EV_ERROR || rsp_tuser == EV_DONE);

   // a stalled result stays offered
   `ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // nothing follows an error or done
   `ASSERT_NEXT(a_silent_after_end, final_take, !rsp_tvalid)
   // last flag only rides on payload bytes
   `ASSERT_SAME(a_last_on_byte, rsp_tvalid && rsp_tlast, rsp_tuser == EV_STR_BYTE)
   // error code set exactly on error items
   `ASSERT_SAME(a_err_code, rsp_tvalid, (rsp_tuser == EV_ERROR) == (rsp_tdata[105:104] != 2'd0))

endmodule

bind bencode_stream_parser bsp_checker u_bsp_checker (.*);

/* tb/sv/tb_bencode_stream_parser.sv */
// Self-checking testbench for the bencode stream parser: random well-formed streams, one random ending.
`timescale 1ns / 1ps

module tb_bencode_stream_parser;
   import bsp_pkg::*;

   localparam int TIMEOUT_NS   = 5_000_000;
   localparam int PHASES       = 8;
   localparam int DEEP_PHASE   = 4;     // phase that starts by nesting to MAX_DEPTH
   localparam int PHASE_ITEMS  = 115;
   localparam int NOISE_ITEMS  = 24;
   localparam int MAX_GAP      = 13;
   localparam int REPORT_LIMIT = 10;
   localparam int RANDOM_NEST  = 10;    // random nesting goes no deeper than this

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_mark;
   } stream_item;

   // How the stream is finally closed. The parser halts after the first error
   // or done, and reset is applied only once, so each run ends exactly one way.
   typedef enum int {
      END_CLEAN,
      END_IN_INT,
      END_IN_LEN,
      END_IN_PAYLOAD,
      END_IN_CONTAINER,
      END_STRAY_E,
      END_UNKNOWN,
      END_ZERO_INT,
      END_ZERO_LEN,
      END_MINUS_ZERO,
      END_BAD_MINUS,
      END_OVERFLOW,
      END_TOO_LONG,
      END_TOO_DEEP,
      END_BAD_DIGIT,
      END_COUNT
   } ending_kind;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = '0;
   logic         req_tuser  = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;
   logic [3:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_valid  = 1'b0;
   logic         csr_ready;
   logic [31:0]  csr_data   = '0;

   bencode_stream_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Parser shadow state, at its reset values
   // ---------------------------------------------------------------------
   mode_type              scan_mode     = MODE_IDLE;
   logic [62:0]           int_mag       = '0;
   logic                  int_negative  = 1'b0;
   logic                  int_has_digit = 1'b0;
   logic [31:0]           len_value     = '0;
   logic [31:0]           payload_left  = '0;
   int                    nest_depth    = 0;
   logic [MAX_DEPTH-1:0]  nest_is_dict  = '0;
   logic                  parser_halted = 1'b0;
   logic [31:0]           string_limit  = 32'hFFFF_FFFF;

   stream_item pending_bytes[$];     // items waiting for the driver
   rsp_type    expected_events[$];   // predicted events, oldest first

   int         items_accepted = 0;
   int         events_checked = 0;
   int         mismatch_count = 0;
   int         limit_writes   = 0;
   int         bytes_built    = 0;
   int         deepest        = 0;
   bit         tx_calm        = 1'b0;
   bit         rx_calm        = 1'b0;
   logic [3:0] tx_wait        = '0;
   logic [3:0] rx_wait        = '0;
   logic [3:0] rx_next;
   stream_item tx_item;
   ending_kind ending         = END_CLEAN;

   // Work out the event (if any) caused by one accepted item.
   function automatic bit parse_step(input logic [7:0] b, input logic mark,
                                     output rsp_type ev);
      bit          hit   = 1'b0;
      event_type   kind  = EV_ERROR;
      error_type   code  = ERR_NONE;
      logic [63:0] sval  = '0;
      logic [31:0] slen  = '0;
      logic [7:0]  pbyte = '0;
      logic        plast = 1'b0;
      logic [67:0] wide;
      logic [3:0]  dig;
      bit          is_digit;
      ev = '0;
      if (parser_halted || scan_mode == MODE_DONE) return 1'b0;
      is_digit = (b >= CH_0) && (b <= CH_9);
      dig      = 4'(b - CH_0);
      if (mark) begin
         hit = 1'b1;
         if (scan_mode == MODE_IDLE && nest_depth == 0) begin
            scan_mode = MODE_DONE;
            kind      = EV_DONE;
         end else code = ERR_PREMATURE;
      end else begin
         case (scan_mode)
            MODE_IDLE: begin
               if (b == CH_D || b == CH_L) begin
                  hit = 1'b1;
                  if (nest_depth >= MAX_DEPTH) code = ERR_RANGE;
                  else begin
                     nest_is_dict[nest_depth] = (b == CH_D);
                     nest_depth++;
                     kind = (b == CH_D) ? EV_DICT_START : EV_LIST_START;
                  end
               end else if (b == CH_E) begin
                  hit = 1'b1;
                  // 'e' with nothing open is a stray end
                  if (nest_depth == 0) code = ERR_MALFORMED;
                  else begin
                     nest_depth--;
                     kind = nest_is_dict[nest_depth] ? EV_DICT_END : EV_LIST_END;
                  end
               end else if (b == CH_I) begin
                  scan_mode     = MODE_INT;
                  int_mag       = '0;
                  int_negative  = 1'b0;
                  int_has_digit = 1'b0;
               end else if (is_digit) begin
                  // the length limit applies from the first digit on
                  if ({28'd0, dig} > string_limit) begin
                     hit  = 1'b1;
                     code = ERR_RANGE;
                  end else begin
                     len_value = {28'd0, dig};
                     scan_mode = MODE_LEN;
                  end
               end else begin
                  hit  = 1'b1;
                  code = ERR_MALFORMED;
               end
            end
            MODE_INT: begin
               if (is_digit) begin
                  wide = {5'd0, int_mag} * 68'd10 + {64'd0, dig};
                  if (int_mag == 0 && int_has_digit) begin
                     hit  = 1'b1;                  // leading zero
                     code = ERR_MALFORMED;
                  end else if (wide > {5'd0, INT_MAX_MAG}) begin
                     hit  = 1'b1;                  // magnitude past 2^63-1
                     code = ERR_RANGE;
                  end else begin
                     int_mag       = wide[62:0];
                     int_has_digit = 1'b1;
                  end
               end else if (b == CH_E) begin
                  hit = 1'b1;
                  if (int_negative && int_mag == 0) code = ERR_MALFORMED;   // minus zero
                  else begin
                     scan_mode = MODE_IDLE;
                     kind      = EV_INT;
                     sval      = int_negative ? -{1'b0, int_mag} : {1'b0, int_mag};
                  end
               end else if (b == CH_MINUS) begin
                  if (int_negative || int_has_digit) begin
                     hit  = 1'b1;
                     code = ERR_MALFORMED;
                  end else int_negative = 1'b1;
               end else begin
                  hit  = 1'b1;
                  code = ERR_MALFORMED;
               end
            end
            MODE_LEN: begin
               if (is_digit) begin
                  wide = {36'd0, len_value} * 68'd10 + {64'd0, dig};
                  if (len_value == 0) begin
                     hit  = 1'b1;
                     code = ERR_MALFORMED;
                  end else if (wide > {36'd0, string_limit}) begin
                     hit  = 1'b1;
                     code = ERR_RANGE;
                  end else len_value = wide[31:0];
               end else if (b == CH_COLON) begin
                  hit          = 1'b1;
                  kind         = EV_STR_START;
                  slen         = len_value;
                  payload_left = len_value;
                  scan_mode    = (len_value == 0) ? MODE_IDLE : MODE_PAYLOAD;
               end else begin
                  hit  = 1'b1;
                  code = ERR_MALFORMED;
               end
            end
            MODE_PAYLOAD: begin
               hit   = 1'b1;
               kind  = EV_STR_BYTE;
               pbyte = b;
               if (payload_left != 0) payload_left--;
               plast = (payload_left == 0);
               if (plast) scan_mode = MODE_IDLE;
            end
            default: hit = 1'b0;
         endcase
      end
      if (code != ERR_NONE) parser_halted = 1'b1;
      if (nest_depth > deepest) deepest = nest_depth;
      ev.event_kind    = kind;
      ev.int_value     = sval;
      ev.string_length = slen;
      ev.payload_byte  = pbyte;
      ev.last_payload  = plast;
      ev.error_code    = code;
      ev.nesting_level = 7'(nest_depth);
      return hit;
   endfunction

   function automatic logic [3:0] draw_gap(bit calm);
      return calm ? 4'd0 : 4'($urandom_range(0, MAX_GAP));
   endfunction

   function automatic void accept_item(logic [7:0] b, logic mark);
      rsp_type ev;
      items_accepted++;
      if (parse_step(b, mark, ev)) expected_events.push_back(ev);
      // switch now and then between gappy and back-to-back sending
      if ($urandom_range(0, 47) == 0) tx_calm = !tx_calm;
   endfunction

   // ---------------------------------------------------------------------
   // Stream building
   // ---------------------------------------------------------------------
   function automatic void push_byte(logic [7:0] b);
      pending_bytes.push_back('{data_byte: b, end_mark: 1'b0});
      bytes_built++;
   endfunction

   // End mark; its data byte is junk the parser must ignore.
   function automatic void push_mark();
      pending_bytes.push_back('{data_byte: 8'($urandom_range(0, 255)), end_mark: 1'b1});
      bytes_built++;
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endfunction

   function automatic void push_decimal(logic [63:0] v);
      logic [7:0] digits[$];
      if (v == 0) digits.push_front(CH_0);
      while (v != 0) begin
         digits.push_front(CH_0 + 8'(v % 10));
         v = v / 10;
      end
      foreach (digits[i]) push_byte(digits[i]);
   endfunction

   function automatic logic [7:0] pick_opener();
      return ($urandom_range(0, 1) != 0) ? CH_D : CH_L;
   endfunction

   function automatic void push_random_int();
      logic [62:0] mag;
      bit          neg;
      int          pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) mag = INT_MAX_MAG;
      else if (pick == 1) mag = '0;
      else mag = 63'({$urandom, $urandom} >> $urandom_range(1, 62));
      neg = (mag != 0) && ($urandom_range(0, 1) != 0);
      // "ie" decodes as zero
      if (pick == 1 && $urandom_range(0, 1) != 0) begin
         push_text("ie");
         return;
      end
      push_byte(CH_I);
      if (neg) push_byte(CH_MINUS);
      push_decimal({1'b0, mag});
      push_byte(CH_E);
   endfunction

   function automatic void push_random_string(logic [31:0] limit);
      int cap;
      int len;
      cap = (limit < 12) ? int'(limit) : 12;
      if (limit >= 40 && $urandom_range(0, 9) == 0) cap = 40;
      len = $urandom_range(0, cap);
      push_decimal(64'(len));
      push_byte(CH_COLON);
      repeat (len) push_byte(8'($urandom_range(0, 255)));
   endfunction

   // Random nested values, all containers closed again at the end.
   function automatic void build_phase(int budget, logic [31:0] limit, bit deep);
      int depth;
      int first;
      int pick;
      depth = 0;
      first = bytes_built;
      if (deep) begin
         repeat (MAX_DEPTH) push_byte(pick_opener());
         depth = MAX_DEPTH;
      end
      while (bytes_built - first < budget) begin
         pick = $urandom_range(0, 99);
         if (depth > 0 && pick < 20) begin
            push_byte(CH_E);
            depth--;
         end else if (pick < 32 && depth < RANDOM_NEST) begin
            push_byte(pick_opener());
            depth++;
         end else if (pick < 64) push_random_int();
         else push_random_string(limit);
      end
      repeat (depth) push_byte(CH_E);
   endfunction

   function automatic void build_ending(logic [31:0] limit);
      logic [7:0] b;
      int         k;
      ending = ending_kind'($urandom_range(0, END_COUNT - 1));
      // most failures may also strike inside an open list
      if (ending != END_CLEAN && ending != END_STRAY_E && ending != END_TOO_DEEP &&
          $urandom_range(0, 1) != 0)
         push_byte(CH_L);
      case (ending)
         END_CLEAN: push_mark();
         END_IN_INT: begin
            push_text("i-12");
            push_mark();
         end
         END_IN_LEN: begin
            push_decimal(64'(limit));
            push_mark();
         end
         END_IN_PAYLOAD: begin
            push_decimal(64'(limit));
            push_byte(CH_COLON);
            if (limit > 5) k = $urandom_range(0, 5);
            else if (limit == 0) k = 0;
            else k = $urandom_range(0, int'(limit) - 1);
            repeat (k) push_byte(8'($urandom_range(0, 255)));
            push_mark();
         end
         END_IN_CONTAINER: begin
            push_byte(pick_opener());
            push_text("i5e");
            push_mark();
         end
         END_STRAY_E: push_byte(CH_E);
         END_UNKNOWN: begin
            do b = 8'($urandom_range(0, 255));
            while (b == CH_D || b == CH_L || b == CH_E || b == CH_I ||
                   (b >= CH_0 && b <= CH_9));
            push_byte(b);
         end
         END_ZERO_INT: begin
            if ($urandom_range(0, 1) != 0) push_text("i01e");
            else push_text("i-05e");
         end
         END_ZERO_LEN: push_text("01:");
         END_MINUS_ZERO: begin
            if ($urandom_range(0, 1) != 0) push_text("i-0e");
            else push_text("i-e");
         end
         END_BAD_MINUS: begin
            if ($urandom_range(0, 1) != 0) push_text("i3-");
            else push_text("i--");
         end
         END_OVERFLOW: begin
            push_byte(CH_I);
            if ($urandom_range(0, 1) != 0) push_byte(CH_MINUS);
            push_decimal(64'h8000_0000_0000_0000);
            push_byte(CH_E);
         end
         END_TOO_LONG: begin
            if (limit == 32'hFFFF_FFFF) push_decimal(64'h1_0000_0000);
            else push_decimal(64'(limit) + 64'd1);
            push_byte(CH_COLON);
         end
         END_TOO_DEEP: repeat (MAX_DEPTH + 1) push_byte(pick_opener());
         END_BAD_DIGIT: push_text("i7x");
         default: push_mark();
      endcase
      // everything after the ending must be swallowed silently
      repeat (NOISE_ITEMS) begin
         if ($urandom_range(0, 3) == 0) push_mark();
         else push_byte(8'($urandom_range(0, 255)));
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driver: one item at a time from pending_bytes, random gap after each
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         tx_wait    <= '0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) accept_item(req_tdata, req_tuser);
         if (tx_wait != 0) begin
            tx_wait    <= tx_wait - 1'b1;
            req_tvalid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            tx_item    = pending_bytes.pop_front();
            req_tdata  <= tx_item.data_byte;
            req_tuser  <= tx_item.end_mark;
            req_tvalid <= 1'b1;
            tx_wait    <= draw_gap(tx_calm);
         end else req_tvalid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compare every event with the oldest prediction
   // ---------------------------------------------------------------------
   task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         if (mismatch_count < REPORT_LIMIT)
            $display("event %0d %s: expected %0h, got %0h", events_checked, name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_event();
      rsp_type want;
      events_checked++;
      if ($urandom_range(0, 47) == 0) rx_calm = !rx_calm;
      if (expected_events.size() == 0) begin
         if (mismatch_count < REPORT_LIMIT)
            $display("event %0d: none expected, got kind %0d", events_checked, rsp_tuser);
         mismatch_count++;
         return;
      end
      want = expected_events.pop_front();
      compare_field("event_kind",    64'(want.event_kind),    64'(rsp_tuser));
      compare_field("int_value",     want.int_value,          rsp_tdata[63:0]);
      compare_field("string_length", 64'(want.string_length), 64'(rsp_tdata[95:64]));
      compare_field("payload_byte",  64'(want.payload_byte),  64'(rsp_tdata[103:96]));
      compare_field("error_code",    64'(want.error_code),    64'(rsp_tdata[105:104]));
      compare_field("nesting_level", 64'(want.nesting_level), 64'(rsp_tdata[112:106]));
      compare_field("last_payload",  64'(want.last_payload),  64'(rsp_tlast));
      compare_field("padding",       64'd0,                   64'(rsp_tdata[119:113]));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_event();
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_wait    <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         // after this item, stall for a random gap drawn into rx_next
         rx_next = draw_gap(rx_calm);
         rx_wait    <= rx_next;
         rsp_tready <= (rx_next == 0);
      end else if (rx_wait != 0) begin
         rx_wait    <= rx_wait - 1'b1;
         rsp_tready <= (rx_wait == 4'd1);
      end else rsp_tready <= 1'b1;
   end

   // ---------------------------------------------------------------------
   // Sequencing
   // ---------------------------------------------------------------------
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_bytes.size() != 0 || req_tvalid || expected_events.size() != 0);
      // items that yield nothing may still be in the two-stage pipe
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid    <= 1'b0;
      string_limit = value;
      limit_writes++;
   endtask

   function automatic logic [31:0] pick_limit(int phase);
      case (phase)
         0:          return 32'd0;       // only empty strings fit
         1:          return 32'd1;
         2:          return 32'($urandom_range(2, 9));
         DEEP_PHASE: return 32'hFFFF_FFFF;
         5:          return 32'($urandom_range(10, 99));
         7:          return 32'($urandom_range(0, 40));
         default:    return $urandom;
      endcase
   endfunction

   initial begin
      logic [31:0] phase_cap;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      write_limit(32'hFFFF_FFFF);
      @(negedge clock);
      // Directed: zero forms, minus one, empty string and containers,
      // one- and two-byte strings with extreme payload bytes.
      push_text("ie");
      push_text("i0e");
      push_text("i-1e");
      push_text("0:");
      push_text("le");
      push_text("de");
      push_text("1:");
      push_byte(8'h00);
      push_text("2:");
      push_byte(8'hFF);
      push_byte(8'h80);
      wait_drained();

      // Random phases, each under its own string length limit. The parser is
      // between values and fully drained before every limit change.
      for (int p = 0; p < PHASES; p++) begin
         phase_cap = pick_limit(p);
         write_limit(phase_cap);
         @(negedge clock);
         build_phase(PHASE_ITEMS, phase_cap, p == DEEP_PHASE);
         wait_drained();
      end

      @(negedge clock);
      build_ending(string_limit);
      wait_drained();
      repeat (20) @(posedge clock);

      $display("Streamed %0d items under %0d length limits, checked %0d parser events.",
               items_accepted, limit_writes, events_checked);
      $display("Nesting reached %0d; stream closed by %s.", deepest, ending.name());
      if (expected_events.size() != 0)
         $display("%0d predicted events never arrived", expected_events.size());
      if (mismatch_count == 0 && expected_events.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timed out, %0d items unsent, %0d events outstanding",
               pending_bytes.size(), expected_events.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* bencode_stream_parser.f */
+incdir+hw/rtl
hw/rtl/bsp_pkg.sv
hw/rtl/bencode_stream_parser.sv
hw/rtl/bsp_checker.sv
tb/sv/tb_bencode_stream_parser.sv
